### sv/cpo_pkg.sv
package cpo_pkg;

    localparam int CoordW = 17;
    localparam int NormW  = 18;
    localparam int ProjW  = 37;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EDGE,
        ST_NORM,
        ST_PROJ,
        ST_CMP,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic store;      // write incoming vertex
        logic edge_rd;    // read edge endpoints
        logic norm_ld;    // latch normal from endpoints
        logic proj_clr;   // start new intervals
        logic proj_step;  // accumulate one projection
        logic proj_rd;    // read vertex for projection
    } t_cmd;

endpackage

### sv/cpo_datapath.sv
module cpo_datapath #(
    parameter int MAX_VERTICES = 16,
    parameter int IW = 4
) (
    input  logic                       i_clk,
    input  cpo_pkg::t_cmd              i_cmd,
    input  logic                       i_wr_poly,
    input  logic [IW-1:0]              i_wr_idx,
    input  logic signed [15:0]         i_vx,
    input  logic signed [15:0]         i_vy,
    input  logic signed [15:0]         i_px,
    input  logic signed [15:0]         i_py,
    input  logic                       i_edge_poly,
    input  logic [IW-1:0]              i_e0,
    input  logic [IW-1:0]              i_e1,
    input  logic                       i_rd_poly,
    input  logic [IW-1:0]              i_rd_idx,
    input  logic                       i_acc_poly,
    input  logic                       i_acc_first,
    output logic                       o_sep
);
    localparam int CW = cpo_pkg::CoordW;
    localparam int NW = cpo_pkg::NormW;
    localparam int PW = cpo_pkg::ProjW;

    logic [2*CW-1:0] r_mem_a [MAX_VERTICES];
    logic [2*CW-1:0] r_mem_b [MAX_VERTICES];
    logic [2*CW-1:0] r_p0, r_p1, r_pv;
    logic signed [NW-1:0] r_nx, r_ny;
    logic signed [PW-1:0] r_mina, r_maxa, r_minb, r_maxb;
    logic signed [CW-1:0] w_wx, w_wy;
    logic signed [NW+CW-1:0] w_mx, w_my;
    logic signed [PW-1:0] w_proj;

    assign w_wx = CW'(i_vx) + CW'(i_px);
    assign w_wy = CW'(i_vy) + CW'(i_py);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            if (i_wr_poly) r_mem_b[i_wr_idx] <= {w_wy, w_wx};
            else r_mem_a[i_wr_idx] <= {w_wy, w_wx};
        end
        if (i_cmd.edge_rd) begin
            r_p0 <= i_edge_poly ? r_mem_b[i_e0] : r_mem_a[i_e0];
            r_p1 <= i_edge_poly ? r_mem_b[i_e1] : r_mem_a[i_e1];
        end
        if (i_cmd.proj_rd) begin
            r_pv <= i_rd_poly ? r_mem_b[i_rd_idx] : r_mem_a[i_rd_idx];
        end
    end

    // normal = (y1 - y0, x0 - x1)
    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_ld) begin
            r_nx <= NW'($signed(r_p1[2*CW-1:CW])) - NW'($signed(r_p0[2*CW-1:CW]));
            r_ny <= NW'($signed(r_p0[CW-1:0])) - NW'($signed(r_p1[CW-1:0]));
        end
    end

    assign w_mx = r_nx * $signed(r_pv[CW-1:0]);
    assign w_my = r_ny * $signed(r_pv[2*CW-1:CW]);
    assign w_proj = PW'(w_mx) + PW'(w_my);

    always_ff @(posedge i_clk) begin
        if (i_cmd.proj_clr) begin
            r_mina <= '0; r_maxa <= '0; r_minb <= '0; r_maxb <= '0;
        end else if (i_cmd.proj_step) begin
            if (i_acc_poly) begin
                if (i_acc_first || w_proj < r_minb) r_minb <= w_proj;
                if (i_acc_first || w_proj > r_maxb) r_maxb <= w_proj;
            end else begin
                if (i_acc_first || w_proj < r_mina) r_mina <= w_proj;
                if (i_acc_first || w_proj > r_maxa) r_maxa <= w_proj;
            end
        end
    end

    assign o_sep = (r_maxa < r_minb) || (r_maxb < r_mina);

endmodule

### sv/cpo_ctrl.sv
module cpo_ctrl #(
    parameter int MAX_VERTICES = 16,
    parameter int IW = 4,
    parameter int CNW = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_fire,
    input  logic               i_action,
    input  logic               i_which,
    input  logic               i_ev,
    input  logic               i_last,
    input  logic               i_out_ready,
    input  logic               i_sep,
    output cpo_pkg::t_cmd      o_cmd,
    output logic [IW-1:0]      o_wr_idx,
    output logic               o_edge_poly,
    output logic [IW-1:0]      o_e0,
    output logic [IW-1:0]      o_e1,
    output logic               o_rd_poly,
    output logic [IW-1:0]      o_rd_idx,
    output logic               o_acc_poly,
    output logic               o_acc_first,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output logic               o_touch,
    output logic               o_block
);
    cpo_pkg::t_state r_state, n_state;
    logic [CNW-1:0] r_cnt_a, r_cnt_b;
    logic [1:0] r_empty, r_ev;
    logic r_a_closed;
    logic r_epoly;
    logic [IW-1:0] r_eidx;
    logic r_ppoly;
    logic [IW-1:0] r_pidx;
    logic r_sv;          // projection read issued last cycle
    logic r_sv_poly, r_sv_first;
    logic r_touch, r_block;
    logic w_pdone, w_edone, w_fin, w_skip, w_go;
    logic [CNW-1:0] w_ca, w_cb, w_ecnt, w_pcnt;
    logic [IW-1:0] w_enext;

    assign w_ca = r_cnt_a;
    assign w_cb = r_cnt_b;
    assign w_ecnt = r_epoly ? w_cb : w_ca;
    assign w_pcnt = r_ppoly ? w_cb : w_ca;
    assign w_enext = ({1'b0, r_eidx} + CNW'(1) == w_ecnt) ? '0 : r_eidx + IW'(1);
    assign w_pdone = r_ppoly && ({1'b0, r_pidx} + CNW'(1) == w_cb);
    assign w_edone = r_epoly && ({1'b0, r_eidx} + CNW'(1) == w_cb);
    assign w_fin = i_in_fire && i_which && (i_last || i_action);
    // skip the axis sweep when either polygon is missing
    assign w_skip = r_empty[0] || r_empty[1] || i_action || (r_cnt_a == '0);

    assign o_in_ready = (r_state == cpo_pkg::ST_LOAD);
    assign o_out_valid = (r_state == cpo_pkg::ST_OUT);
    assign o_touch = r_touch;
    assign o_block = r_block;
    assign o_wr_idx = i_which ? r_cnt_b[IW-1:0] : (r_a_closed ? '0 : r_cnt_a[IW-1:0]);
    assign o_edge_poly = r_epoly;
    assign o_e0 = r_eidx;
    assign o_e1 = w_enext;
    assign o_rd_poly = r_ppoly;
    assign o_rd_idx = r_pidx;
    assign o_acc_poly = r_sv_poly;
    assign o_acc_first = r_sv_first;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cpo_pkg::ST_LOAD: begin
                if (w_fin) n_state = w_skip ? cpo_pkg::ST_OUT : cpo_pkg::ST_EDGE;
            end
            cpo_pkg::ST_EDGE: n_state = cpo_pkg::ST_NORM;
            cpo_pkg::ST_NORM: n_state = cpo_pkg::ST_PROJ;
            cpo_pkg::ST_PROJ: begin
                if (w_pdone) n_state = cpo_pkg::ST_CMP;
            end
            cpo_pkg::ST_CMP: begin
                if (!r_sv) begin
                    if (i_sep || w_edone) n_state = cpo_pkg::ST_OUT;
                    else n_state = cpo_pkg::ST_EDGE;
                end
            end
            cpo_pkg::ST_OUT: begin
                if (i_out_ready) n_state = cpo_pkg::ST_LOAD;
            end
            default: n_state = cpo_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            cpo_pkg::ST_LOAD: begin
                o_cmd.store = i_in_fire && !i_action
                    && ((i_which ? r_cnt_b : ((r_a_closed) ? '0 : r_cnt_a))
                        < CNW'(MAX_VERTICES));
            end
            cpo_pkg::ST_EDGE: o_cmd.edge_rd = 1'b1;
            cpo_pkg::ST_NORM: begin
                o_cmd.norm_ld = 1'b1;
                o_cmd.proj_clr = 1'b1;
            end
            cpo_pkg::ST_PROJ: begin
                o_cmd.proj_rd = 1'b1;
                o_cmd.proj_step = r_sv;
            end
            cpo_pkg::ST_CMP: o_cmd.proj_step = r_sv;
            default: o_cmd = '0;
        endcase
    end

    assign w_go = (r_state == cpo_pkg::ST_LOAD) && w_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpo_pkg::ST_LOAD;
            r_cnt_a <= '0; r_cnt_b <= '0;
            r_empty <= '0; r_ev <= '0; r_a_closed <= 1'b0;
            r_sv <= 1'b0;
            r_touch <= 1'b0; r_block <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sv <= (r_state == cpo_pkg::ST_PROJ);
            if (r_state == cpo_pkg::ST_LOAD && i_in_fire) begin
                if (!i_which) begin
                    r_ev[0] <= i_ev;
                    if (i_action) begin
                        r_cnt_a <= '0;
                        r_empty[0] <= 1'b1;
                    end else if (r_a_closed) begin
                        r_cnt_a <= CNW'(1);
                        r_empty[0] <= 1'b0;
                    end else if (r_cnt_a < CNW'(MAX_VERTICES)) begin
                        r_cnt_a <= r_cnt_a + CNW'(1);
                    end
                    r_a_closed <= i_last || i_action;
                end else begin
                    r_ev[1] <= i_ev;
                    if (i_action) begin
                        r_cnt_b <= '0;
                        r_empty[1] <= 1'b1;
                    end else if (r_cnt_b < CNW'(MAX_VERTICES)) begin
                        r_cnt_b <= r_cnt_b + CNW'(1);
                    end
                end
            end
            if (w_go && w_skip) begin
                r_touch <= 1'b0;
                r_block <= 1'b0;
            end
            if (r_state == cpo_pkg::ST_CMP && !r_sv && (i_sep || w_edone)) begin
                r_touch <= !i_sep;
                r_block <= !i_sep && (r_ev != 2'b11);
            end
            if (r_state == cpo_pkg::ST_OUT && i_out_ready) begin
                r_cnt_a <= '0; r_cnt_b <= '0;
                r_empty <= '0; r_ev <= '0; r_a_closed <= 1'b0;
            end
        end
    end

    // edge and projection walkers
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_epoly <= 1'b0;
            r_eidx <= '0;
        end else if (r_state == cpo_pkg::ST_CMP && !r_sv && !i_sep && !w_edone) begin
            if ({1'b0, r_eidx} + CNW'(1) == w_ecnt) begin
                r_epoly <= 1'b1;
                r_eidx <= '0;
            end else begin
                r_eidx <= r_eidx + IW'(1);
            end
        end
        if (r_state == cpo_pkg::ST_NORM) begin
            r_ppoly <= 1'b0;
            r_pidx <= '0;
        end else if (r_state == cpo_pkg::ST_PROJ) begin
            if ({1'b0, r_pidx} + CNW'(1) == w_pcnt) begin
                r_ppoly <= 1'b1;
                r_pidx <= '0;
            end else begin
                r_pidx <= r_pidx + IW'(1);
            end
        end
        r_sv_poly <= r_ppoly;
        r_sv_first <= (r_pidx == '0);
    end

endmodule

### sv/convex_polygon_overlap_sat_core.sv
// Separating-axis overlap test for two convex 2D polygons. Stream polygon A's
// vertices, then B's, one per beat; tdata carries local vertex plus body position
// (summed on entry), tuser the action and polygon select, tlast the final vertex.
// A result beat (touching, blocking) follows B's final or action beat only. tready
// stays high throughout loading; the test visits each edge normal of A then B,
// projecting every vertex of both polygons per axis on the single projection
// multiplier pair, and stops at the first separating axis. No beats are taken
// meanwhile.
module convex_polygon_overlap_sat_core #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // vert_x[15:0], vert_y[31:16], pos_x[47:32], pos_y[63:48], events_only[64]
    input  logic [71:0] s_axis_tdata,
    // action[0], which_poly[1]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // touching[0], blocking[1]
    output logic [7:0]  m_axis_tdata
);
    localparam int IW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNW = $clog2(MAX_VERTICES + 1);

    cpo_pkg::t_cmd w_cmd;
    logic [IW-1:0] w_wr_idx, w_e0, w_e1, w_rd_idx;
    logic w_edge_poly, w_rd_poly, w_acc_poly, w_acc_first, w_sep;
    logic w_touch, w_block, w_fire;

    assign w_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata = {6'b0, w_block, w_touch};

    cpo_ctrl #(.MAX_VERTICES(MAX_VERTICES), .IW(IW), .CNW(CNW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_action(s_axis_tuser[0]), .i_which(s_axis_tuser[1]),
        .i_ev(s_axis_tdata[64]), .i_last(s_axis_tlast),
        .i_out_ready(m_axis_tready), .i_sep(w_sep), .o_cmd(w_cmd),
        .o_wr_idx(w_wr_idx), .o_edge_poly(w_edge_poly), .o_e0(w_e0), .o_e1(w_e1),
        .o_rd_poly(w_rd_poly), .o_rd_idx(w_rd_idx), .o_acc_poly(w_acc_poly),
        .o_acc_first(w_acc_first), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_touch(w_touch), .o_block(w_block)
    );

    cpo_datapath #(.MAX_VERTICES(MAX_VERTICES), .IW(IW)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_wr_poly(s_axis_tuser[1]),
        .i_wr_idx(w_wr_idx),
        .i_vx(s_axis_tdata[15:0]), .i_vy(s_axis_tdata[31:16]),
        .i_px(s_axis_tdata[47:32]), .i_py(s_axis_tdata[63:48]),
        .i_edge_poly(w_edge_poly), .i_e0(w_e0), .i_e1(w_e1),
        .i_rd_poly(w_rd_poly), .i_rd_idx(w_rd_idx),
        .i_acc_poly(w_acc_poly), .i_acc_first(w_acc_first), .o_sep(w_sep)
    );

endmodule
